// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define B32E_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define B32E_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/b32e_pkg.sv -----
// ----------------------------------------------------------------------------
// Base32 multibase encoder package
// Payload types, constants and the symbol lookup shared by the encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MAX_CHARS       = 4;
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic [7:0]  PREFIX_CHAR    = 8'h62;  // ASCII 'b'
  localparam logic [4:0]  SYMBOL_MASK    = 5'h1F;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_message;
  } b32e_in_t;

  // One output beat.
  typedef struct packed {
    logic [7:0]  character;
    logic        last_char;
    logic        status;
    logic [15:0] char_count;
  } b32e_out_t;

  // Characters produced by one input beat, before the capacity check.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [1:0]                final_idx;  // index of the last valid character
    logic                      last;       // beat closes the message
    logic                      restart;    // discard the running count first
  } b32e_rec_t;

  // Lowercase base32 alphabet: a..z then 2..7.
  function automatic logic [7:0] b32_symbol(input logic [4:0] v);
    logic [7:0] sym;
    if (v < 5'd26) begin
      sym = 8'h61 + {3'b000, v};
    end else begin
      sym = 8'h32 + {3'b000, v - 5'd26};
    end
    return sym;
  endfunction

endpackage

// ----- rtl/core/b32e_slicer.sv -----
// ----------------------------------------------------------------------------
// Base32 bit slicer
// Splits each input byte plus carried bits into 5-bit symbols and registers
// the characters of one beat as a record for the emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b32e_slicer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  b32e_pkg::b32e_in_t in_data,
  output logic               rec_valid,
  output b32e_pkg::b32e_rec_t rec,
  input  logic               rec_take
);
  import b32e_pkg::*;

  logic [3:0] leftover_bits, leftover_bits_next;
  logic [2:0] leftover_count, leftover_count_next;
  logic       message_started, message_started_next;
  b32e_rec_t  rec_next;
  logic       in_fire;

  logic [11:0] acc;
  logic [3:0]  nbits;
  logic        two_syms;
  logic [3:0]  sh0;
  logic [3:0]  sh1;
  logic [2:0]  rem;
  logic [11:0] rem_mask;
  logic [3:0]  rem_bits;
  logic [4:0]  flush_sym;
  logic [2:0]  k;

  assign in_ready = !rec_valid || rec_take;
  assign in_fire  = in_valid && in_ready;

  // Slice the carried bits and the new byte into symbols.
  always_comb begin
    acc      = {leftover_bits, in_data.data_byte};
    nbits    = {1'b0, leftover_count} + 4'd8;
    two_syms = (nbits >= 4'd10);
    sh0      = nbits - 4'd5;
    sh1      = nbits - 4'd10;
    rem      = two_syms ? sh1[2:0] : sh0[2:0];
    rem_mask = (12'd1 << rem) - 12'd1;
    rem_bits = 4'(acc & rem_mask);
    flush_sym = (5'(rem_bits) << (3'd5 - rem)) & SYMBOL_MASK;

    rec_next       = '0;
    k              = 3'd0;
    leftover_bits_next   = leftover_bits;
    leftover_count_next  = leftover_count;
    message_started_next = message_started;

    if (in_data.empty_message) begin
      rec_next.chars[0]   = PREFIX_CHAR;
      rec_next.final_idx  = 2'd0;
      rec_next.last       = 1'b1;
      rec_next.restart    = 1'b1;
      leftover_bits_next   = '0;
      leftover_count_next  = '0;
      message_started_next = 1'b0;
    end else begin
      if (!message_started) begin
        rec_next.chars[k[1:0]] = PREFIX_CHAR;
        k = k + 3'd1;
      end
      rec_next.chars[k[1:0]] = b32_symbol(5'(acc >> sh0) & SYMBOL_MASK);
      k = k + 3'd1;
      if (two_syms) begin
        rec_next.chars[k[1:0]] = b32_symbol(5'(acc >> sh1) & SYMBOL_MASK);
        k = k + 3'd1;
      end
      if (in_data.last_byte && (rem != 3'd0)) begin
        rec_next.chars[k[1:0]] = b32_symbol(flush_sym);
        k = k + 3'd1;
      end
      rec_next.final_idx = 2'(k - 3'd1);
      rec_next.last      = in_data.last_byte;
      rec_next.restart   = 1'b0;
      if (in_data.last_byte) begin
        leftover_bits_next   = '0;
        leftover_count_next  = '0;
        message_started_next = 1'b0;
      end else begin
        leftover_bits_next   = rem_bits;
        leftover_count_next  = rem;
        message_started_next = 1'b1;
      end
    end
  end

  // Carry state and record valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits   <= '0;
      leftover_count  <= '0;
      message_started <= 1'b0;
      rec_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        leftover_bits   <= leftover_bits_next;
        leftover_count  <= leftover_count_next;
        message_started <= message_started_next;
      end
      rec_valid <= in_fire || (rec_valid && !rec_take);
    end
  end

  // Record payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec <= rec_next;
    end
  end

  `B32E_ASSERT(a_leftover_range, clk, rst, leftover_count <= 3'd4, "leftover count above four")
  `B32E_ASSERT(a_idle_no_carry, clk, rst, !message_started |-> leftover_count == 3'd0, "carry outside a message")
  `B32E_ASSERT(a_ready_when_free, clk, rst, !rec_valid |-> in_ready, "input held off with no record")

endmodule

// ----- rtl/core/b32e_emit.sv -----
// ----------------------------------------------------------------------------
// Base32 character emitter
// Drains a record into the output register a character per cycle unless
// stalled, applies the capacity limit, reports status/count on the final beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b32e_emit #(
  parameter int COUNT_WIDTH = b32e_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         capacity,
  input  logic                rec_valid,
  input  b32e_pkg::b32e_rec_t rec,
  output logic                rec_take,
  output logic                out_valid,
  input  logic                out_ready,
  output b32e_pkg::b32e_out_t out_data
);
  import b32e_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  b32e_rec_t              cur;
  logic                   cur_valid;
  logic [1:0]             cur_idx;
  logic [COUNT_WIDTH-1:0] emitted_count, emitted_count_next;
  logic                   overflowed, overflowed_next;
  b32e_out_t              out_next;

  logic                   step;
  logic                   at_end;
  logic                   load;
  logic                   fits;
  logic                   finish;
  logic [COUNT_WIDTH-1:0] count_after;
  logic                   ovf_after;
  logic [CMP_W-1:0]       count_ext;

  assign step     = cur_valid && (!out_valid || out_ready);
  assign at_end   = (cur_idx == cur.final_idx);
  assign load     = !cur_valid || (step && at_end);
  assign rec_take = load && rec_valid;

  // Capacity check and count update for the character being emitted.
  always_comb begin
    fits = (CMP_W'(emitted_count) < CMP_W'(capacity)) && (emitted_count != '1);
    count_after = fits ? emitted_count + COUNT_WIDTH'(1) : emitted_count;
    ovf_after   = overflowed || !fits;
    finish      = cur.last && at_end;
    count_ext   = CMP_W'(count_after);

    out_next           = '0;
    out_next.character = fits ? cur.chars[cur_idx] : 8'h00;
    out_next.last_char = finish;
    out_next.status    = finish && ovf_after;
    out_next.char_count = finish ? count_ext[15:0] : 16'h0000;

    emitted_count_next = emitted_count;
    overflowed_next    = overflowed;
    if (step) begin
      emitted_count_next = finish ? '0 : count_after;
      overflowed_next    = finish ? 1'b0 : ovf_after;
    end
    // An empty message drops whatever was counted so far.
    if (rec_take && rec.restart) begin
      emitted_count_next = '0;
      overflowed_next    = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      cur_idx       <= '0;
      emitted_count <= '0;
      overflowed    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      emitted_count <= emitted_count_next;
      overflowed    <= overflowed_next;
      if (load) begin
        cur_valid <= rec_valid;
        cur_idx   <= '0;
      end else if (step) begin
        cur_idx <= cur_idx + 2'd1;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rec_take) begin
      cur <= rec;
    end
    if (step) begin
      out_data <= out_next;
    end
  end

  `B32E_ASSERT(a_clear_after_final, clk, rst, (step && finish) |=> (emitted_count == '0 && !overflowed), "count not cleared after final beat")
  `B32E_ASSERT(a_idx_in_record, clk, rst, cur_valid |-> cur_idx <= cur.final_idx, "character index past record end")
  `B32E_ASSERT(a_summary_on_final, clk, rst, (out_valid && !out_data.last_char) |-> (!out_data.status && out_data.char_count == 16'h0000), "summary fields set on a non-final beat")

endmodule

// ----- rtl/core/base32_multibase_encoder.sv -----
// ----------------------------------------------------------------------------
// Base32 multibase encoder top level
// Usage: the in channel takes one message byte per beat (data_byte, with
// last_byte on the final byte, or empty_message alone for a zero-length
// message). The out channel gives one character per beat: the prefix 'b',
// then lowercase base32 symbols, with last_char, status and char_count
// meaningful on the final beat of a message.
// A byte passes the slicer's record register and the emitter's current
// record register to the output register, which moves one character per
// cycle unless out_ready holds it. A byte gives 1 to 3 characters (its
// prefix or second symbol, one symbol, flush symbol), 1.6 on a long message.
// The beat register between the slicer and the emitter lets a new byte be
// taken while the previous one's characters still drain.
// cfg_we/cfg_wdata set the capacity; write it only while idle.
// Reset clears the carried bits, the count and the pipeline, and sets the
// capacity to 65535. When out_ready is low the output beat holds, the
// emitter and then the slicer fill, and in_ready falls.
// ----------------------------------------------------------------------------
module base32_multibase_encoder #(
  parameter int COUNT_WIDTH = b32e_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b32e_pkg::b32e_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b32e_pkg::b32e_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import b32e_pkg::*;

  logic [15:0] capacity;
  logic        rec_valid;
  logic        rec_take;
  b32e_rec_t   rec;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  b32e_slicer u_slicer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take)
  );

  b32e_emit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/base32_multibase_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 multibase encoder testbench
// Sends directed and random messages through the encoder and checks every
// output beat against an in-bench prediction of the character stream. It
// covers several capacity settings, random gaps on both channels and one
// long output stall.
// ----------------------------------------------------------------------------
module base32_multibase_encoder_tb;
  import b32e_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int COUNT_LIMIT   = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int PHASE_ITEMS   = 52;
  localparam int NUM_PHASES    = 8;

  // Tracks the encoder state and holds the characters still to come out.
  class char_scoreboard;
    logic [15:0] capacity;
    logic [3:0]  carry_bits;
    int          carry_count;
    bit          started;
    int          emitted;
    bit          overflow;
    int          errors;
    string       alphabet;
    b32e_out_t   expected_chars[$];

    function new();
      alphabet = "abcdefghijklmnopqrstuvwxyz234567";
      capacity = CAPACITY_RESET;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      carry_bits  = '0;
      carry_count = 0;
      started     = 1'b0;
      emitted     = 0;
      overflow    = 1'b0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // One character slot; past the capacity it is suppressed as a zero.
    function void push_char(logic [7:0] ch);
      b32e_out_t r;
      r = '0;
      if (emitted < int'(capacity) && emitted < COUNT_LIMIT) begin
        r.character = ch;
        emitted++;
      end else begin
        overflow = 1'b1;
      end
      expected_chars.push_back(r);
    endfunction

    // Marks the newest expected beat as the end of the message.
    function void close_message();
      b32e_out_t r;
      r = expected_chars.pop_back();
      r.last_char  = 1'b1;
      r.status     = overflow;
      r.char_count = 16'(emitted);
      expected_chars.push_back(r);
    endfunction

    // Works out the characters caused by one accepted input beat.
    function void note_byte_beat(b32e_in_t v);
      int acc;
      int nbits;
      int idx;
      if (v.empty_message) begin
        restart();
        push_char(PREFIX_CHAR);
        close_message();
        restart();
        return;
      end
      if (!started) begin
        started = 1'b1;
        push_char(PREFIX_CHAR);
      end
      acc   = (int'(carry_bits) << 8) | int'(v.data_byte);
      nbits = carry_count + 8;
      while (nbits >= 5) begin
        nbits -= 5;
        idx = (acc >> nbits) & int'(SYMBOL_MASK);
        push_char(alphabet[idx]);
      end
      carry_count = nbits;
      carry_bits  = 4'(acc & ((1 << nbits) - 1));
      if (v.last_byte) begin
        // Leftover bits are padded with zeros on the right.
        if (carry_count > 0) begin
          idx = (int'(carry_bits) << (5 - carry_count)) & int'(SYMBOL_MASK);
          push_char(alphabet[idx]);
        end
        close_message();
        restart();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    // Compares one output beat with the oldest expected character.
    task check_char_beat(b32e_out_t got);
      b32e_out_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected output beat %0h", got));
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character)
        report($sformatf("character %02h, expected %02h", got.character, want.character));
      if (got.last_char !== want.last_char)
        report($sformatf("last_char %b, expected %b", got.last_char, want.last_char));
      if (got.status !== want.status)
        report($sformatf("status %b, expected %b", got.status, want.status));
      if (got.char_count !== want.char_count)
        report($sformatf("char_count %0d, expected %0d", got.char_count, want.char_count));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  b32e_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  b32e_out_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  char_scoreboard sb;
  int items_sent;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;

  base32_multibase_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Sender idle gaps: mostly none or short, now and then long.
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stall lengths; never zero so each ready change is its own cycle.
  function automatic int rx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // Offers one input beat and waits until it is taken.
  task automatic send_beat(input b32e_in_t v);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte_beat(v);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] d, input bit last);
    b32e_in_t v;
    v.data_byte     = d;
    v.last_byte     = last;
    v.empty_message = 1'b0;
    send_beat(v);
  endtask

  // A zero-length message; the byte and last bits ride along and are ignored.
  task automatic send_empty(input logic [7:0] d, input bit last);
    b32e_in_t v;
    v.data_byte     = d;
    v.last_byte     = last;
    v.empty_message = 1'b1;
    send_beat(v);
  endtask

  task automatic send_message(input int nbytes, input bit finish_msg);
    for (int i = 0; i < nbytes; i++)
      send_byte(8'($urandom), finish_msg && (i == nbytes - 1));
  endtask

  // Capacity is changed only once the encoder has drained.
  task automatic set_capacity(input logic [15:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.capacity  = v;
  endtask

  // Mostly complete messages, some empty ones, some cut short by an empty beat.
  task automatic run_traffic(input int target);
    int stop_at;
    int r;
    int len;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      r   = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      if (r < 72) begin
        send_message(len, 1'b1);
      end else if (r < 82) begin
        send_empty(8'($urandom), 1'($urandom));
      end else begin
        send_message($urandom_range(1, 4), 1'b0);
        send_empty(8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Output ready: random runs, steady stretches and one long hold-off.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (rx_gap()) @(posedge clk);
      end
    end
  end

  // Every accepted output beat is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_char_beat(out_data);
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cap;
    sb           = new();
    items_sent   = 0;
    quiet_cycles = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    rx_hold_req  = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity.
    send_empty(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Forty bits fill eight symbols with nothing left to flush.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);
    // One, four and two leftover bits at the end of the message.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b1);
    // An empty beat in the middle drops the unfinished message.
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_empty(8'h00, 1'b0);

    // Random phases over several capacities, the extremes among them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          cap = 16'd1;
        end
        1: begin
          cap = 16'd0;
        end
        2: begin
          cap = 16'hFFFF;
        end
        NUM_PHASES - 1: begin
          cap = 16'($urandom_range(100, 65534));
        end
        default: begin
          cap = 16'($urandom_range(2, 12));
        end
      endcase
      set_capacity(cap);
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      // The long output stall backs the encoder up into its input.
      if (p == 2) rx_hold_req = 1'b1;
      run_traffic(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected characters never arrived");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
